### rtl/swap_slot_bitmap_allocator_defines.svh
// Assertion macros shared by the swap slot bitmap allocator RTL.
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SSBA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define SSBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssba_pkg.sv
// Package with the codes, widths and transfer types of the swap slot allocator.
`timescale 1ns / 1ps

package ssba_pkg;

    // Field widths of the request, the result and the configuration register.
    localparam int MODE_W = 2;
    localparam int IDX_W  = 12;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 13;
    localparam int CFG_W  = 13;

    // Default geometry of the bitmap.
    localparam int SSBA_SLOTS_DEF     = 4096;
    localparam int SSBA_WORD_BITS_DEF = 32;

    // Reset value of the active slot register and the saturation point of the count.
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 13'd4096;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 13'h1FFF;

    // Operation codes; the unused code behaves as a query.
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd2;

    // One request as it enters the engine.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  slot_index;
    } ssba_req_t;

    // One result as it leaves the engine.
    typedef struct packed {
        logic [IDX_W-1:0]  slot;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  in_use_count;
    } ssba_rsp_t;

endpackage

### rtl/ssba_bitmap_ram.sv
// Single-port-write, single-port-read bitmap memory with a registered read.
`timescale 1ns / 1ps

module ssba_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ssba_engine.sv
// Sequencer that clears, scans and updates the slot bitmap and keeps the in-use count.
`timescale 1ns / 1ps

module ssba_engine
    import ssba_pkg::*;
#(
    parameter int SLOTS     = SSBA_SLOTS_DEF,
    parameter int WORD_BITS = SSBA_WORD_BITS_DEF,
    parameter int NUM_WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS,
    parameter int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CFG_W-1:0]     active_slots,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ssba_req_t            req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output ssba_rsp_t            rsp,
    output logic                 ram_we,
    output logic [WORD_AW-1:0]   ram_waddr,
    output logic [WORD_BITS-1:0] ram_wdata,
    output logic                 ram_re,
    output logic [WORD_AW-1:0]   ram_raddr,
    input  logic [WORD_BITS-1:0] ram_rdata
);

    // WORD_BITS is a power of two: a slot index splits into word and bit fields.
    localparam int BIT_AW = $clog2(WORD_BITS);
    localparam int LIM_W  = $clog2(SLOTS + 1);

    typedef enum logic [4:0] {
        ST_CLEAR    = 5'b00001,
        ST_IDLE     = 5'b00010,
        ST_SCAN     = 5'b00100,
        ST_FREE_MOD = 5'b01000,
        ST_RESP     = 5'b10000
    } ssba_state_t;

    ssba_state_t          state_reg, state_next;
    logic [WORD_AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [WORD_AW-1:0]   chk_word_reg, chk_word_next;
    logic [LIM_W-1:0]     full_words_reg, full_words_next;
    logic [LIM_W-1:0]     last_word_reg, last_word_next;
    logic [WORD_BITS-1:0] part_mask_reg, part_mask_next;
    logic [WORD_AW-1:0]   free_word_reg, free_word_next;
    logic [BIT_AW-1:0]    bit_sel_reg, bit_sel_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    ssba_rsp_t            rsp_reg, rsp_next;

    logic [LIM_W-1:0]     lim;
    logic [LIM_W-1:0]     full_words;
    logic [BIT_AW-1:0]    part;
    logic [WORD_BITS-1:0] part_mask;
    logic [31:0]          idx_ext;
    logic                 idx_oob;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic                 found;
    logic [BIT_AW-1:0]    found_bit;
    logic [31:0]          slot_ext;
    logic [CNT_W-1:0]     count_inc;
    logic [CNT_W-1:0]     count_dec;

    // Effective limit: the register clamped to the bitmap size, split into words.
    always_comb begin
        lim        = (32'(active_slots) > 32'(SLOTS)) ? LIM_W'(SLOTS) : LIM_W'(active_slots);
        full_words = lim >> BIT_AW;
        part       = lim[BIT_AW-1:0];
        for (int b = 0; b < WORD_BITS; b++) begin
            part_mask[b] = (BIT_AW'(b) < part);
        end
        idx_ext = 32'(req.slot_index);
        idx_oob = (idx_ext >= 32'(lim));
    end

    // Free bits of the word under examination and the lowest one among them.
    always_comb begin
        word_mask = (LIM_W'(chk_word_reg) < full_words_reg) ? '1 : part_mask_reg;
        free_bits = ~ram_rdata & word_mask;
        found     = |free_bits;
        found_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                found_bit = BIT_AW'(b);
            end
        end
        slot_ext = (32'(chk_word_reg) << BIT_AW) | 32'(found_bit);
    end

    // Saturating count steps.
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + CNT_W'(1);
    assign count_dec = (count_reg == '0) ? count_reg : count_reg - CNT_W'(1);

    // Sequencer: clearing pass, request decode, word scan, read-modify-write, response.
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        chk_word_next   = chk_word_reg;
        full_words_next = full_words_reg;
        last_word_next  = last_word_reg;
        part_mask_next  = part_mask_reg;
        free_word_next  = free_word_reg;
        bit_sel_next    = bit_sel_reg;
        count_next      = count_reg;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_word_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = chk_word_reg + WORD_AW'(1);

        case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + WORD_AW'(1);
                if (clr_addr_reg == WORD_AW'(NUM_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_valid) begin
                    full_words_next       = full_words;
                    last_word_next        = (part != '0) ? full_words : full_words - LIM_W'(1);
                    part_mask_next        = part_mask;
                    free_word_next        = idx_ext[BIT_AW +: WORD_AW];
                    bit_sel_next          = idx_ext[BIT_AW-1:0];
                    rsp_next.slot         = '0;
                    rsp_next.status       = STATUS_OK;
                    rsp_next.in_use_count = count_reg;
                    case (req.mode)
                        MODE_ALLOC: begin
                            if (lim == '0) begin
                                rsp_next.status = STATUS_NOSPACE;
                                state_next      = ST_RESP;
                            end else begin
                                ram_re        = 1'b1;
                                ram_raddr     = '0;
                                chk_word_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        MODE_FREE: begin
                            if (idx_oob) begin
                                rsp_next.status = STATUS_RANGE;
                                state_next      = ST_RESP;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = idx_ext[BIT_AW +: WORD_AW];
                                state_next = ST_FREE_MOD;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // The next word is fetched while this one is examined.
                ram_re = 1'b1;
                if (found) begin
                    ram_we                = 1'b1;
                    ram_waddr             = chk_word_reg;
                    ram_wdata             = ram_rdata | (WORD_BITS'(1) << found_bit);
                    count_next            = count_inc;
                    rsp_next.slot         = slot_ext[IDX_W-1:0];
                    rsp_next.status       = STATUS_OK;
                    rsp_next.in_use_count = count_inc;
                    state_next            = ST_RESP;
                end else if (LIM_W'(chk_word_reg) == last_word_reg) begin
                    rsp_next.status = STATUS_NOSPACE;
                    state_next      = ST_RESP;
                end else begin
                    chk_word_next = chk_word_reg + WORD_AW'(1);
                end
            end
            ST_FREE_MOD: begin
                // Clearing an already free bit still lowers the count.
                ram_we                = 1'b1;
                ram_waddr             = free_word_reg;
                ram_wdata             = ram_rdata & ~(WORD_BITS'(1) << bit_sel_reg);
                count_next            = count_dec;
                rsp_next.in_use_count = count_dec;
                state_next            = ST_RESP;
            end
            ST_RESP: begin
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
        end
    end

    // Per-request working registers.
    always_ff @(posedge aclk) begin
        chk_word_reg   <= chk_word_next;
        full_words_reg <= full_words_next;
        last_word_reg  <= last_word_next;
        part_mask_reg  <= part_mask_next;
        free_word_reg  <= free_word_next;
        bit_sel_reg    <= bit_sel_next;
        rsp_reg        <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_RESP);
    assign rsp       = rsp_reg;

endmodule

### rtl/swap_slot_bitmap_allocator.sv
// Allocate: the scan reads one bitmap word per cycle from the memory's single read
// port until it sets a free bit or reaches the last word. Free reads the word and
// writes it back; query goes straight to the response. The next input is taken in
// the cycle after the result moves to the output register, so one item is in work
// at a time. Reset (aresetn low, synchronous) clears the count, loads active_slots
// with 4096, then a clearing pass zeroes the bitmap.
`timescale 1ns / 1ps
`include "swap_slot_bitmap_allocator_defines.svh"

module swap_slot_bitmap_allocator
    import ssba_pkg::*;
#(
    parameter int SLOTS     = SSBA_SLOTS_DEF,
    parameter int WORD_BITS = SSBA_WORD_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [MODE_W-1:0] s_mode,
    input  logic [IDX_W-1:0]  s_slot_index,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IDX_W-1:0]  m_slot,
    output logic [STAT_W-1:0] m_status,
    output logic [CNT_W-1:0]  m_in_use_count
);

    localparam int NUM_WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic [CFG_W-1:0]     active_slots_reg, active_slots_next;
    logic                 m_valid_reg, m_valid_next;
    ssba_rsp_t            m_rsp_reg;
    ssba_req_t            req;
    ssba_rsp_t            rsp;
    logic                 rsp_valid;
    logic                 rsp_ready;
    logic                 ram_we;
    logic [WORD_AW-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WORD_AW-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Configuration register; the user must write it only while the block is idle, as the block does not enforce this.
    assign cfg_ready         = 1'b1;
    assign active_slots_next = (cfg_valid && cfg_ready) ? cfg_data : active_slots_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_slots_reg <= ACTIVE_RESET;
        end else begin
            active_slots_reg <= active_slots_next;
        end
    end

    assign req.mode       = s_mode;
    assign req.slot_index = s_slot_index;

    ssba_bitmap_ram #(
        .DEPTH (NUM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (WORD_AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ssba_engine #(
        .SLOTS     (SLOTS),
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS),
        .WORD_AW   (WORD_AW)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .active_slots (active_slots_reg),
        .req_valid    (s_valid),
        .req_ready    (s_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    // Output register: holds a finished result until its transfer completes.
    assign rsp_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (rsp_valid && rsp_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_valid && rsp_ready) begin
            m_rsp_reg <= rsp;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_slot         = m_rsp_reg.slot;
    assign m_status       = m_rsp_reg.status;
    assign m_in_use_count = m_rsp_reg.in_use_count;

    // A failed operation never reports a slot.
    `SSBA_ASSERT_SAME(a_fail_slot_zero, aclk, aresetn, m_valid && (m_status != STATUS_OK), m_slot == '0, "failed operation reports a nonzero slot")

    // Only one request is in work: the input closes right after a transfer.
    `SSBA_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_valid && s_ready, !s_ready, "input still open after a transfer")

endmodule
